@@ rtl/dtpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared types and constants of the dual throttle plausibility check.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int TOL_W     = 13;
  localparam int RUN_W     = 8;
  localparam int SCALED_W  = 12;
  localparam int VALUE_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_A_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_FULL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_FULL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAINTAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN = 3'd6;

  localparam logic [TOL_W-1:0] TOL_RESET      = 13'd1600;
  localparam logic [RUN_W-1:0] MAINTAIN_RESET = 8'd2;
  localparam logic [RUN_W-1:0] SHUTDOWN_RESET = 8'd50;

  localparam logic [SCALED_W-1:0] SAT_MAX = 12'd4095;
  localparam logic [RUN_W-1:0]    RUN_MAX = 8'd255;

  localparam logic [1:0] OUTCOME_OK      = 2'd0;
  localparam logic [1:0] OUTCOME_WARNING = 2'd1;
  localparam logic [1:0] OUTCOME_FATAL   = 2'd2;

  localparam logic [1:0] CLASS_NONE    = 2'd0;
  localparam logic [1:0] CLASS_WARNING = 2'd1;
  localparam logic [1:0] CLASS_FATAL   = 2'd2;

  typedef struct packed {
    logic                neg;
    logic                sat;
    logic [SCALED_W-1:0] mag;
  } dtpc_lane_res_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic [RUN_W-1:0] maintain;
    logic [RUN_W-1:0] shutdown;
  } dtpc_limits_t;

endpackage

@@ rtl/dtpc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_in_if
// Request channel carrying one pair of raw pedal sensor samples.
// ----------------------------------------------------------------------------
interface dtpc_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_a;
  logic [ADC_BITS-1:0] raw_b;

  modport source (output valid, output raw_a, output raw_b, input ready);
  modport sink   (input valid, input raw_a, input raw_b, output ready);
endinterface

@@ rtl/dtpc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_out_if
// Result channel carrying one plausibility verdict per request.
// ----------------------------------------------------------------------------
interface dtpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] pedal_value;
  logic [1:0]         outcome;
  logic               shutdown_request;
  logic [1:0]         error_class;
  logic [7:0]         mismatch_count;
  logic [11:0]        scaled_a;
  logic [11:0]        scaled_b;

  modport source (output valid, output pedal_value, output outcome,
                  output shutdown_request, output error_class,
                  output mismatch_count, output scaled_a, output scaled_b,
                  input ready);
  modport sink   (input valid, input pedal_value, input outcome,
                  input shutdown_request, input error_class,
                  input mismatch_count, input scaled_a, input scaled_b,
                  output ready);
endinterface

@@ rtl/dtpc_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_lane
// One sensor lane: scales the offset reading by full scale and divides it
// by the span with a radix-2 restoring divider, truncating toward zero.
// ----------------------------------------------------------------------------
module dtpc_lane #(
  parameter int ADC_BITS   = 10,
  parameter int FULL_SCALE = 1200
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ADC_BITS:0]         num,
  input  logic signed [ADC_BITS:0]         span,
  input  logic                             ack,
  output logic                             done,
  output dtpc_pkg::dtpc_lane_res_t         res
);
  import dtpc_pkg::*;

  localparam int FS_W = $clog2(FULL_SCALE + 1);
  localparam int PW   = ADC_BITS + FS_W;
  localparam int CW   = $clog2(PW);
  localparam int QW   = (PW > SCALED_W) ? PW : SCALED_W + 1;
  localparam logic [FS_W-1:0] FS_VAL = FS_W'(FULL_SCALE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0] num_mag_r, num_mag_nxt;
  logic [ADC_BITS-1:0] span_mag_r, span_mag_nxt;
  logic                sign_r, sign_nxt;
  logic                zero_r, zero_nxt;
  logic [PW-1:0]       q_r, q_nxt;
  logic [ADC_BITS-1:0] rem_r, rem_nxt;
  logic [ADC_BITS:0]   trial;
  logic                ge;
  logic [ADC_BITS:0]   num_neg, span_neg;
  logic [QW-1:0]       q_ext;

  assign num_neg  = -num;
  assign span_neg = -span;
  assign trial    = {rem_r, q_r[PW-1]};
  assign ge       = trial >= {1'b0, span_mag_r};

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    num_mag_nxt  = num_mag_r;
    span_mag_nxt = span_mag_r;
    sign_nxt     = sign_r;
    zero_nxt     = zero_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          num_mag_nxt  = num[ADC_BITS] ? num_neg[ADC_BITS-1:0] : num[ADC_BITS-1:0];
          span_mag_nxt = span[ADC_BITS] ? span_neg[ADC_BITS-1:0] : span[ADC_BITS-1:0];
          sign_nxt     = num[ADC_BITS] ^ span[ADC_BITS];
          zero_nxt     = (span == '0);
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        q_nxt     = PW'(num_mag_r) * PW'(FS_VAL);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? ADC_BITS'(trial - {1'b0, span_mag_r}) : trial[ADC_BITS-1:0];
        q_nxt   = {q_r[PW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    num_mag_r  <= num_mag_nxt;
    span_mag_r <= span_mag_nxt;
    sign_r     <= sign_nxt;
    zero_r     <= zero_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
  end

  assign q_ext = QW'(q_r);

  always_comb begin
    if (zero_r) begin
      res.neg = 1'b0;
      res.sat = 1'b0;
      res.mag = '0;
    end else begin
      res.neg = sign_r && (q_r != '0);
      res.sat = q_ext > QW'(SAT_MAX);
      res.mag = q_ext[SCALED_W-1:0];
    end
  end

  assign done = (state_r == ST_DONE);

endmodule

@@ rtl/dtpc_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpc_merge
// Combines both lane results: clamps, compares, runs the mismatch counter,
// holds the error state and registers the result request.
// ----------------------------------------------------------------------------
module dtpc_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     lanes_done,
  input  dtpc_pkg::dtpc_lane_res_t res_a,
  input  dtpc_pkg::dtpc_lane_res_t res_b,
  input  dtpc_pkg::dtpc_limits_t   limits,
  output logic                     take,
  dtpc_out_if.source               out_ch
);
  import dtpc_pkg::*;

  logic                      out_valid_r;
  logic [RUN_W-1:0]          run_r, run_nxt;
  logic                      shut_r, shut_nxt;
  logic [1:0]                class_r, class_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [1:0]                outcome_r, outcome_nxt;
  logic [SCALED_W-1:0]       sa_r, sb_r;
  logic [SCALED_W-1:0]       sa, sb, ca, cb;
  logic [SCALED_W:0]         diff_raw, sum;
  logic [SCALED_W-1:0]       diff;
  logic                      mismatch;

  assign ca = res_a.sat ? SAT_MAX : res_a.mag;
  assign cb = res_b.sat ? SAT_MAX : res_b.mag;
  assign sa = (res_a.neg || res_b.neg) ? '0 : ca;
  assign sb = (res_a.neg || res_b.neg) ? '0 : cb;

  assign diff_raw = {1'b0, sa} - {1'b0, sb};
  assign diff     = diff_raw[SCALED_W] ? SCALED_W'(-diff_raw) : diff_raw[SCALED_W-1:0];
  assign mismatch = {1'b0, diff} >= limits.tol;
  assign sum      = {1'b0, sa} + {1'b0, sb};

  always_comb begin
    if (!mismatch) begin
      run_nxt = '0;
    end else if (run_r == RUN_MAX) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + 1'b1;
    end
    shut_nxt  = shut_r;
    class_nxt = class_r;
    if (run_nxt <= limits.maintain) begin
      value_nxt   = VALUE_W'(sum[SCALED_W:1]);
      outcome_nxt = OUTCOME_OK;
    end else if (run_nxt > limits.shutdown) begin
      value_nxt   = '1;
      outcome_nxt = OUTCOME_FATAL;
      shut_nxt    = 1'b1;
      class_nxt   = CLASS_FATAL;
    end else begin
      value_nxt   = '0;
      outcome_nxt = OUTCOME_WARNING;
      shut_nxt    = 1'b0;
      class_nxt   = CLASS_WARNING;
    end
  end

  assign take = lanes_done && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= '0;
      shut_r      <= 1'b0;
      class_r     <= CLASS_NONE;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        run_r       <= run_nxt;
        shut_r      <= shut_nxt;
        class_r     <= class_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_r   <= value_nxt;
      outcome_r <= outcome_nxt;
      sa_r      <= sa;
      sb_r      <= sb;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pedal_value      = value_r;
  assign out_ch.outcome          = outcome_r;
  assign out_ch.shutdown_request = shut_r;
  assign out_ch.error_class      = class_r;
  assign out_ch.mismatch_count   = run_r;
  assign out_ch.scaled_a         = sa_r;
  assign out_ch.scaled_b         = sb_r;

endmodule

@@ rtl/dual_throttle_plausibility_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_throttle_plausibility_check
// Maps two redundant pedal sensors in parallel lanes, checks that they agree
// and reports the averaged pedal position, a warning or a fatal shutdown.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    raw_a, raw_b
//   out_ch   out  valid/ready    pedal_value .. scaled_b
//   cfg_*    in   write enable   cfg_index, cfg_data
//
// Each lane scales its offset reading and then divides it by the span bit-serially;
// one request is in work at a time; input stays busy until the result is taken.
// A finished result sits in the output register while the next request runs.
// Synchronous active-low reset restores register defaults and clears the state.
// A stalled output only holds the lanes once their next result is ready.
// ----------------------------------------------------------------------------
module dual_throttle_plausibility_check #(
  parameter int FULL_SCALE = 1200,
  parameter int ADC_BITS   = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dtpc_in_if.sink                              in_ch,
  dtpc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [dtpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((ADC_BITS > dtpc_pkg::TOL_W) ? ADC_BITS : dtpc_pkg::TOL_W)-1:0] cfg_data
);
  import dtpc_pkg::*;

  logic [ADC_BITS-1:0] a_offset_r, a_full_r, b_offset_r, b_full_r;
  logic [TOL_W-1:0]    tol_r;
  logic [RUN_W-1:0]    maintain_r, shutdown_r;
  logic                busy_r;
  logic                in_take;
  logic                take;
  logic                done_a, done_b;
  logic signed [ADC_BITS:0] num_a, span_a, num_b, span_b;
  dtpc_lane_res_t      res_a, res_b;
  dtpc_limits_t        limits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_offset_r <= '0;
      a_full_r   <= '1;
      b_offset_r <= '0;
      b_full_r   <= '1;
      tol_r      <= TOL_RESET;
      maintain_r <= MAINTAIN_RESET;
      shutdown_r <= SHUTDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_OFFSET: a_offset_r <= cfg_data[ADC_BITS-1:0];
        REG_A_FULL:   a_full_r   <= cfg_data[ADC_BITS-1:0];
        REG_B_OFFSET: b_offset_r <= cfg_data[ADC_BITS-1:0];
        REG_B_FULL:   b_full_r   <= cfg_data[ADC_BITS-1:0];
        REG_TOL:      tol_r      <= cfg_data[TOL_W-1:0];
        REG_MAINTAIN: maintain_r <= cfg_data[RUN_W-1:0];
        REG_SHUTDOWN: shutdown_r <= cfg_data[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !busy_r;
  assign in_take     = in_ch.valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_take) begin
      busy_r <= 1'b1;
    end else if (take) begin
      busy_r <= 1'b0;
    end
  end

  assign num_a  = {1'b0, in_ch.raw_a} - {1'b0, a_offset_r};
  assign span_a = {1'b0, a_full_r} - {1'b0, a_offset_r};
  assign num_b  = {1'b0, b_full_r} - {1'b0, in_ch.raw_b};
  assign span_b = {1'b0, b_full_r} - {1'b0, b_offset_r};

  dtpc_lane #(.ADC_BITS(ADC_BITS), .FULL_SCALE(FULL_SCALE)) u_lane_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .num   (num_a),
    .span  (span_a),
    .ack   (take),
    .done  (done_a),
    .res   (res_a)
  );

  dtpc_lane #(.ADC_BITS(ADC_BITS), .FULL_SCALE(FULL_SCALE)) u_lane_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .num   (num_b),
    .span  (span_b),
    .ack   (take),
    .done  (done_b),
    .res   (res_b)
  );

  assign limits.tol      = tol_r;
  assign limits.maintain = maintain_r;
  assign limits.shutdown = shutdown_r;

  dtpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lanes_done (done_a && done_b),
    .res_a      (res_a),
    .res_b      (res_b),
    .limits     (limits),
    .take       (take),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_shut_matches_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.shutdown_request == (out_ch.error_class == CLASS_FATAL)))
    else $error("shutdown request disagrees with held error class");

  a_fatal_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.outcome == OUTCOME_FATAL) |->
      (out_ch.pedal_value == -13'sd1 && out_ch.error_class == CLASS_FATAL))
    else $error("fatal result without fatal value or class");

  a_ok_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.outcome == OUTCOME_OK) |-> !out_ch.pedal_value[VALUE_W-1])
    else $error("ok result with negative pedal value");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (done_a == done_b))
    else $error("sensor lanes finished out of step");
`endif

endmodule

@@ tb/sv/dual_throttle_plausibility_check_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_throttle_plausibility_check_tb
// Drives pairs of pedal sensor samples through the plausibility check while
// the register settings change between request batches. Both channels idle
// and stall at random. An in-bench model of the sensor mapping, the mismatch
// run counter and the held shutdown and error class predicts every verdict,
// and each returned verdict is compared field by field in request order.
// ----------------------------------------------------------------------------
module dual_throttle_plausibility_check_tb;
  import dtpc_pkg::*;

  localparam int FULL_SCALE      = 1200;
  localparam int ADC_BITS        = 10;
  localparam int CFG_DATA_W      = (ADC_BITS > TOL_W) ? ADC_BITS : TOL_W;
  localparam int RANDOM_REQUESTS = 650;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int ADC_MAX         = (1 << ADC_BITS) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]  pedal_value;
    logic [1:0]          outcome;
    logic                shutdown_request;
    logic [1:0]          error_class;
    logic [RUN_W-1:0]    mismatch_count;
    logic [SCALED_W-1:0] scaled_a;
    logic [SCALED_W-1:0] scaled_b;
  } verdict_t;

  class pedal_verdict_model;
    logic [ADC_BITS-1:0] a_offset, a_full, b_offset, b_full;
    logic [TOL_W-1:0]    tolerance;
    logic [RUN_W-1:0]    maintain, shutdown;
    logic [RUN_W-1:0]    run;
    logic                held_shutdown;
    logic [1:0]          held_class;
    verdict_t            pending_verdicts[$];
    int                  errors, checked, ok_seen, warn_seen, fatal_seen, peak_run;

    function new();
      a_offset      = '0;
      a_full        = ADC_MAX;
      b_offset      = '0;
      b_full        = ADC_MAX;
      tolerance     = TOL_RESET;
      maintain      = MAINTAIN_RESET;
      shutdown      = SHUTDOWN_RESET;
      run           = '0;
      held_shutdown = 1'b0;
      held_class    = CLASS_NONE;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_A_OFFSET: a_offset  = data[ADC_BITS-1:0];
        REG_A_FULL:   a_full    = data[ADC_BITS-1:0];
        REG_B_OFFSET: b_offset  = data[ADC_BITS-1:0];
        REG_B_FULL:   b_full    = data[ADC_BITS-1:0];
        REG_TOL:      tolerance = data[TOL_W-1:0];
        REG_MAINTAIN: maintain  = data[RUN_W-1:0];
        REG_SHUTDOWN: shutdown  = data[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint map_lane(longint num, longint span);
      longint v;
      if (span == 0) return 0;
      v = (num * FULL_SCALE) / span;
      if (v > longint'(SAT_MAX)) v = longint'(SAT_MAX);
      return v;
    endfunction

    function void note_request(logic [ADC_BITS-1:0] raw_a, logic [ADC_BITS-1:0] raw_b);
      longint   sa, sbv, diff, value;
      verdict_t v;
      sa  = map_lane(longint'(raw_a) - longint'(a_offset),
                     longint'(a_full) - longint'(a_offset));
      sbv = map_lane(longint'(b_full) - longint'(raw_b),
                     longint'(b_full) - longint'(b_offset));
      if (sa < 0 || sbv < 0) begin
        sa  = 0;
        sbv = 0;
      end
      diff = (sa > sbv) ? sa - sbv : sbv - sa;
      if (diff < longint'(tolerance)) run = '0;
      else if (run != RUN_MAX) run = run + 1'b1;
      if (run <= maintain) begin
        value     = (sa + sbv) / 2;
        v.outcome = OUTCOME_OK;
      end else if (run > shutdown) begin
        held_shutdown = 1'b1;
        held_class    = CLASS_FATAL;
        value         = -1;
        v.outcome     = OUTCOME_FATAL;
      end else begin
        held_shutdown = 1'b0;
        held_class    = CLASS_WARNING;
        value         = 0;
        v.outcome     = OUTCOME_WARNING;
      end
      v.pedal_value      = value[VALUE_W-1:0];
      v.shutdown_request = held_shutdown;
      v.error_class      = held_class;
      v.mismatch_count   = run;
      v.scaled_a         = sa[SCALED_W-1:0];
      v.scaled_b         = sbv[SCALED_W-1:0];
      if (int'(run) > peak_run) peak_run = run;
      pending_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict returned with no request outstanding");
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      case (want.outcome)
        OUTCOME_OK:      ok_seen++;
        OUTCOME_WARNING: warn_seen++;
        default:         fatal_seen++;
      endcase
      compare_field("pedal_value", $signed(want.pedal_value), $signed(got.pedal_value));
      compare_field("outcome", want.outcome, got.outcome);
      compare_field("shutdown_request", want.shutdown_request, got.shutdown_request);
      compare_field("error_class", want.error_class, got.error_class);
      compare_field("mismatch_count", want.mismatch_count, got.mismatch_count);
      compare_field("scaled_a", want.scaled_a, got.scaled_a);
      compare_field("scaled_b", want.scaled_b, got.scaled_b);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  int                    idle_cycles;
  int                    settings_used;

  pedal_verdict_model verdicts = new();

  dtpc_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  dtpc_out_if out_ch ();

  dual_throttle_plausibility_check #(
    .FULL_SCALE(FULL_SCALE),
    .ADC_BITS  (ADC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // request, verdict and register write monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) verdicts.write_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) verdicts.note_request(in_ch.raw_a, in_ch.raw_b);
      if (out_ch.valid && out_ch.ready)
        verdicts.check_result('{out_ch.pedal_value, out_ch.outcome, out_ch.shutdown_request,
                                out_ch.error_class, out_ch.mismatch_count,
                                out_ch.scaled_a, out_ch.scaled_b});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dual_throttle_plausibility_check: mismatch");
        $finish;
      end
    end
  end

  // verdict side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      int stall;
      if (calm) begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic send_request(input int raw_a, input int raw_b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.raw_a = raw_a[ADC_BITS-1:0];
    in_ch.raw_b = raw_b[ADC_BITS-1:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] dress(int val, int w);
    int mask;
    mask = (1 << w) - 1;
    if ($urandom_range(0, 1)) return CFG_DATA_W'(val & mask);
    return CFG_DATA_W'(($urandom & ~mask) | (val & mask));
  endfunction

  function automatic int corner_value();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return ADC_MAX;
      default: return $urandom_range(0, ADC_MAX);
    endcase
  endfunction

  task automatic random_settings(input bit zero_tol);
    int a_off, a_top, b_off, b_top, tol, keep, stop;
    case ($urandom_range(0, 5))
      0: begin
        a_off = $urandom_range(0, ADC_MAX);
        a_top = $urandom_range(0, ADC_MAX);
        b_off = $urandom_range(0, ADC_MAX);
        b_top = $urandom_range(0, ADC_MAX);
      end
      1: begin
        a_off = $urandom_range(0, ADC_MAX);
        a_top = $urandom_range(0, 1) ? a_off : $urandom_range(0, ADC_MAX);
        b_off = $urandom_range(0, ADC_MAX);
        b_top = $urandom_range(0, 1) ? b_off : $urandom_range(0, ADC_MAX);
      end
      default: begin
        a_off = $urandom_range(0, 200);
        a_top = $urandom_range(800, ADC_MAX);
        b_off = $urandom_range(0, 200);
        b_top = $urandom_range(800, ADC_MAX);
      end
    endcase
    case ($urandom_range(0, 4))
      0:       tol = 0;
      1:       tol = $urandom_range(1, 40);
      2:       tol = $urandom_range(41, 1600);
      3:       tol = $urandom_range(1601, 4096);
      default: tol = $urandom_range(0, 8191);
    endcase
    if (zero_tol) tol = 0;
    keep = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) stop = $urandom_range(0, 255);
    else stop = (keep + $urandom_range(0, 10) > 255) ? 255 : keep + $urandom_range(0, 10);
    cfg_write(REG_A_OFFSET, dress(a_off, ADC_BITS));
    cfg_write(REG_A_FULL,   dress(a_top, ADC_BITS));
    cfg_write(REG_B_OFFSET, dress(b_off, ADC_BITS));
    cfg_write(REG_B_FULL,   dress(b_top, ADC_BITS));
    cfg_write(REG_TOL,      CFG_DATA_W'(tol));
    cfg_write(REG_MAINTAIN, dress(keep, RUN_W));
    cfg_write(REG_SHUTDOWN, dress(stop, RUN_W));
    if ($urandom_range(0, 7) == 0) cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic random_request();
    int p, ra, rb;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // pair that follows one pedal position, with a little sensor noise
        p  = $urandom_range(0, FULL_SCALE);
        ra = int'(verdicts.a_offset) +
             p * (int'(verdicts.a_full) - int'(verdicts.a_offset)) / FULL_SCALE;
        rb = int'(verdicts.b_full) -
             p * (int'(verdicts.b_full) - int'(verdicts.b_offset)) / FULL_SCALE;
        ra = ra + $urandom_range(0, 16) - 8;
        rb = rb + $urandom_range(0, 16) - 8;
        if (ra < 0) ra = 0;
        if (ra > ADC_MAX) ra = ADC_MAX;
        if (rb < 0) rb = 0;
        if (rb > ADC_MAX) rb = ADC_MAX;
      end
      6, 7: begin
        ra = $urandom_range(0, ADC_MAX);
        rb = $urandom_range(0, ADC_MAX);
      end
      default: begin
        ra = corner_value();
        rb = corner_value();
      end
    endcase
    send_request(ra, rb);
  endtask

  initial begin
    int random_sent, len, k;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_a = '0;
    in_ch.raw_b = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    calm        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // register defaults, pedal extremes
    send_request(0, 0);
    send_request(ADC_MAX, ADC_MAX);
    send_request(0, ADC_MAX);
    send_request(ADC_MAX, 0);
    send_request(512, 511);
    send_request(341, 682);
    send_request(1, ADC_MAX - 1);

    // narrow span saturates, zero span on b, negative a, zero tolerance walks to fatal
    drain();
    cfg_write(REG_A_OFFSET, 13'd100);
    cfg_write(REG_A_FULL,   13'd200);
    cfg_write(REG_B_OFFSET, 13'd1023);
    cfg_write(REG_B_FULL,   13'd1023);
    cfg_write(REG_TOL,      13'd0);
    cfg_write(REG_MAINTAIN, 13'd1);
    cfg_write(REG_SHUTDOWN, 13'd3);
    cfg_we = 1'b0;
    settings_used++;
    send_request(ADC_MAX, 5);
    send_request(150, 0);
    send_request(50, 0);
    send_request(200, ADC_MAX);
    send_request(0, 0);
    send_request(ADC_MAX, ADC_MAX);

    // reversed span on a, widest tolerance: ok samples keep the held fatal state
    drain();
    cfg_write(REG_A_OFFSET, 13'h1F84);
    cfg_write(REG_A_FULL,   13'd100);
    cfg_write(REG_B_OFFSET, 13'd0);
    cfg_write(REG_B_FULL,   13'd1023);
    cfg_write(REG_TOL,      13'd4096);
    cfg_write(REG_MAINTAIN, 13'd0);
    cfg_write(REG_SHUTDOWN, 13'd0);
    cfg_write(REG_SPARE,    13'h1FFF);
    cfg_we = 1'b0;
    settings_used++;
    send_request(0, 0);
    send_request(500, 511);
    send_request(ADC_MAX, 300);
    send_request(850, 1000);

    // warnings clear the held shutdown
    drain();
    cfg_write(REG_TOL,      13'd0);
    cfg_write(REG_MAINTAIN, 13'h1F00);
    cfg_write(REG_SHUTDOWN, 13'h1EFF);
    cfg_we = 1'b0;
    settings_used++;
    send_request(600, 400);
    send_request(0, ADC_MAX);
    send_request(ADC_MAX, 0);

    random_sent = 0;
    k = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      if (k == 2) begin
        // long enough with zero tolerance for the run counter to saturate
        random_settings(1'b1);
        len = 270;
      end else begin
        random_settings(1'b0);
        len = $urandom_range(15, 50);
      end
      if (len > RANDOM_REQUESTS - random_sent) len = RANDOM_REQUESTS - random_sent;
      repeat (len) random_request();
      random_sent += len;
      k++;
    end
    drain();
    calm = 1'b1;
    repeat (40) @(posedge clk);

    if (verdicts.pending() != 0) begin
      $error("%0d verdicts never returned", verdicts.pending());
      verdicts.errors++;
    end
    $display("checked %0d verdicts over %0d register settings: %0d ok, %0d warning, %0d fatal",
             verdicts.checked, settings_used, verdicts.ok_seen, verdicts.warn_seen,
             verdicts.fatal_seen);
    $display("longest mismatch run %0d", verdicts.peak_run);
    if (verdicts.errors == 0) begin
      $display("dual_throttle_plausibility_check: match");
    end else begin
      $display("dual_throttle_plausibility_check: mismatch");
    end
    $finish;
  end

endmodule
